// ===== design/fet_pkg.sv =====
// ----------------------------------------------------------------------------
// fet_pkg
// Types, constants and helpers shared by the escape-time fractal engine.
// ----------------------------------------------------------------------------
package fet_pkg;

    localparam int FRAC_BITS     = 28;
    localparam int ITER_BITS     = 16;
    localparam int PIXEL_BITS    = 12;
    localparam int WORD_BITS     = 32;
    localparam int STEP_BITS     = 31;
    localparam int RADIUS_BITS   = 32;
    localparam int HALF_BITS     = 16;
    localparam int PROD_BITS     = 2 * WORD_BITS;
    localparam int SUM_BITS      = PROD_BITS + 2;
    localparam int ROOT_BITS     = HALF_BITS + 1;
    localparam int SQ_OP_BITS    = 2 * ROOT_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_X_MIN     = 3'd0,
        CFG_Y_MIN     = 3'd1,
        CFG_STEP      = 3'd2,
        CFG_RADIUS_SQ = 3'd3,
        CFG_MAX_ITER  = 3'd4,
        CFG_MODE      = 3'd5,
        CFG_C_RE      = 3'd6,
        CFG_C_IM      = 3'd7
    } t_cfg_idx;

    localparam logic signed [WORD_BITS-1:0] RST_X_MIN     = -32'sd536870912;
    localparam logic signed [WORD_BITS-1:0] RST_Y_MIN     = -32'sd536870912;
    localparam logic [STEP_BITS-1:0]        RST_STEP      = 31'd1048576;
    localparam logic [RADIUS_BITS-1:0]      RST_RADIUS_SQ = 32'd67108864;
    localparam logic [ITER_BITS-1:0]        RST_MAX_ITER  = 16'd256;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
    } t_pixel_in;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] out_x;
        logic [PIXEL_BITS-1:0] out_y;
        logic [ITER_BITS-1:0]  iteration_count;
        logic                  inside_two;
        logic [HALF_BITS-1:0]  half_modulus;
    } t_result;

    typedef struct packed {
        logic load;
        logic map;
        logic init;
        logic square;
        logic step;
        logic root_start;
    } t_fet_cmd;

    typedef struct packed {
        logic go_on;
        logic root_done;
    } t_fet_status;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-WORD_BITS:0] upper;
        logic signed [WORD_BITS-1:0] res;
        upper = v[SUM_BITS-1:WORD_BITS-1];
        if ((&upper) || !(|upper)) begin
            res = v[WORD_BITS-1:0];
        end else if (v[SUM_BITS-1]) begin
            res = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== design/fet_sqrt.sv =====
// ----------------------------------------------------------------------------
// fet_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fet_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fet_pkg::SQ_OP_BITS-1:0]    i_op,
    output logic                              o_done,
    output logic [fet_pkg::ROOT_BITS-1:0]     o_root
);

    localparam int REM_BITS = fet_pkg::ROOT_BITS + 3;
    localparam int CNT_BITS = $clog2(fet_pkg::ROOT_BITS + 1);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(fet_pkg::ROOT_BITS - 1);

    logic [fet_pkg::SQ_OP_BITS-1:0] r_op;
    logic [REM_BITS-1:0]            r_rem;
    logic [fet_pkg::ROOT_BITS-1:0]  r_root;
    logic [CNT_BITS-1:0]            r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [REM_BITS-1:0] w_rem_sh;
    logic [REM_BITS-1:0] w_trial;

    assign w_rem_sh = {r_rem[REM_BITS-3:0], r_op[fet_pkg::SQ_OP_BITS-1 -: 2]};
    assign w_trial  = REM_BITS'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_op;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op <= {r_op[fet_pkg::SQ_OP_BITS-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[fet_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[fet_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/fet_dp.sv =====
// ----------------------------------------------------------------------------
// fet_dp
// Datapath: configuration registers, point mapping, z*z + c iteration,
// escape test and final modulus.
// ----------------------------------------------------------------------------
module fet_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fet_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [fet_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  fet_pkg::t_pixel_in                  i_pixel,
    input  fet_pkg::t_fet_cmd                   i_cmd,
    output fet_pkg::t_fet_status                o_status,
    output fet_pkg::t_result                    o_result
);

    localparam int WB         = fet_pkg::WORD_BITS;
    localparam int PB         = fet_pkg::PROD_BITS;
    localparam int SB         = fet_pkg::SUM_BITS;
    localparam int FB         = fet_pkg::FRAC_BITS;
    localparam int ESC_SHIFT  = 2 * FB - 24;
    localparam int ROOT_SHIFT = 2 * FB - 30;
    localparam bit INSIDE_ALL = (2 * FB + 2 >= PB);
    localparam int INSIDE_SH  = INSIDE_ALL ? 0 : 2 * FB + 2;
    localparam int M2X_BITS   = PB + 1;
    localparam int MAP_BITS   = fet_pkg::PIXEL_BITS + fet_pkg::STEP_BITS;

    logic signed [WB-1:0]                  r_x_min;
    logic signed [WB-1:0]                  r_y_min;
    logic [fet_pkg::STEP_BITS-1:0]         r_step;
    logic [fet_pkg::RADIUS_BITS-1:0]       r_radius;
    logic [fet_pkg::ITER_BITS-1:0]         r_max_iter;
    logic                                  r_mode;
    logic signed [WB-1:0]                  r_jc_re;
    logic signed [WB-1:0]                  r_jc_im;

    logic [fet_pkg::PIXEL_BITS-1:0]        r_px;
    logic [fet_pkg::PIXEL_BITS-1:0]        r_py;
    logic signed [WB-1:0]                  r_pre;
    logic signed [WB-1:0]                  r_pim;
    logic signed [WB-1:0]                  r_zr;
    logic signed [WB-1:0]                  r_zi;
    logic signed [WB-1:0]                  r_c_re;
    logic signed [WB-1:0]                  r_c_im;
    logic [fet_pkg::ITER_BITS-1:0]         r_count;
    logic signed [PB-1:0]                  r_prr;
    logic signed [PB-1:0]                  r_pii;
    logic signed [PB-1:0]                  r_pri;
    logic                                  r_inside;

    logic [MAP_BITS-1:0]                   w_off_x;
    logic [MAP_BITS-1:0]                   w_off_y;
    logic signed [SB-1:0]                  w_map_re;
    logic signed [SB-1:0]                  w_map_im;
    logic signed [PB-1:0]                  w_mul_rr;
    logic signed [PB-1:0]                  w_mul_ii;
    logic signed [PB-1:0]                  w_mul_ri;
    logic [PB-1:0]                         w_rr;
    logic [PB-1:0]                         w_ii;
    logic signed [PB-1:0]                  w_ri;
    logic signed [SB-1:0]                  w_re_sum;
    logic signed [SB-1:0]                  w_im_sum;
    logic [PB-1:0]                         w_m2;
    logic                                  w_esc_ok;
    logic                                  w_inside;
    logic                                  w_root_done;
    logic [fet_pkg::ROOT_BITS-1:0]         w_root;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min    <= fet_pkg::RST_X_MIN;
            r_y_min    <= fet_pkg::RST_Y_MIN;
            r_step     <= fet_pkg::RST_STEP;
            r_radius   <= fet_pkg::RST_RADIUS_SQ;
            r_max_iter <= fet_pkg::RST_MAX_ITER;
            r_mode     <= 1'b0;
            r_jc_re    <= '0;
            r_jc_im    <= '0;
        end else if (i_cfg_we) begin
            case (fet_pkg::t_cfg_idx'(i_cfg_idx))
                fet_pkg::CFG_X_MIN:     r_x_min    <= i_cfg_data[WB-1:0];
                fet_pkg::CFG_Y_MIN:     r_y_min    <= i_cfg_data[WB-1:0];
                fet_pkg::CFG_STEP:      r_step     <= i_cfg_data[fet_pkg::STEP_BITS-1:0];
                fet_pkg::CFG_RADIUS_SQ: r_radius   <= i_cfg_data[fet_pkg::RADIUS_BITS-1:0];
                fet_pkg::CFG_MAX_ITER:  r_max_iter <= i_cfg_data[fet_pkg::ITER_BITS-1:0];
                fet_pkg::CFG_MODE:      r_mode     <= i_cfg_data[0];
                fet_pkg::CFG_C_RE:      r_jc_re    <= i_cfg_data[WB-1:0];
                fet_pkg::CFG_C_IM:      r_jc_im    <= i_cfg_data[WB-1:0];
                default: ;
            endcase
        end
    end

    // point mapping
    assign w_off_x  = MAP_BITS'(r_px) * MAP_BITS'(r_step);
    assign w_off_y  = MAP_BITS'(r_py) * MAP_BITS'(r_step);
    assign w_map_re = SB'(r_x_min) + $signed(SB'(w_off_x));
    assign w_map_im = SB'(r_y_min) + $signed(SB'(w_off_y));

    // squares and cross product of z
    assign w_mul_rr = r_zr * r_zr;
    assign w_mul_ii = r_zi * r_zi;
    assign w_mul_ri = r_zr * r_zi;

    // next z from the registered products
    assign w_rr     = $unsigned(r_prr) >> FB;
    assign w_ii     = $unsigned(r_pii) >> FB;
    assign w_ri     = r_pri >>> (FB - 1);
    assign w_re_sum = $signed(SB'(w_rr)) - $signed(SB'(w_ii)) + SB'(r_c_re);
    assign w_im_sum = SB'(w_ri) + SB'(r_c_im);

    // escape test on |z|^2
    assign w_m2     = $unsigned(r_prr) + $unsigned(r_pii);
    assign w_esc_ok = (w_m2 >> ESC_SHIFT) < PB'(r_radius);
    assign w_inside = INSIDE_ALL || ({1'b0, w_m2} <= (M2X_BITS'(1) << INSIDE_SH));

    assign o_status.go_on     = (r_count == '0) || (w_esc_ok && (r_count < r_max_iter));
    assign o_status.root_done = w_root_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel.pixel_x;
            r_py <= i_pixel.pixel_y;
        end
        if (i_cmd.map) begin
            r_pre <= fet_pkg::sat_word(w_map_re);
            r_pim <= fet_pkg::sat_word(w_map_im);
        end
        if (i_cmd.init) begin
            r_count <= '0;
            if (r_mode) begin
                r_zr   <= r_pre;
                r_zi   <= r_pim;
                r_c_re <= r_jc_re;
                r_c_im <= r_jc_im;
            end else begin
                r_zr   <= '0;
                r_zi   <= '0;
                r_c_re <= r_pre;
                r_c_im <= r_pim;
            end
        end
        if (i_cmd.square) begin
            r_prr <= w_mul_rr;
            r_pii <= w_mul_ii;
            r_pri <= w_mul_ri;
        end
        if (i_cmd.step) begin
            r_zr    <= fet_pkg::sat_word(w_re_sum);
            r_zi    <= fet_pkg::sat_word(w_im_sum);
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.root_start) begin
            r_inside <= w_inside;
        end
    end

    fet_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_op    (fet_pkg::SQ_OP_BITS'(w_m2 >> ROOT_SHIFT)),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    assign o_result.out_x           = r_px;
    assign o_result.out_y           = r_py;
    assign o_result.iteration_count = r_count;
    assign o_result.inside_two      = r_inside;
    assign o_result.half_modulus    = !r_inside ? '0 :
                                      w_root[fet_pkg::ROOT_BITS-1] ? '1 :
                                      w_root[fet_pkg::HALF_BITS-1:0];

endmodule

// ===== design/fet_ctrl.sv =====
// ----------------------------------------------------------------------------
// fet_ctrl
// Controller: sequences mapping, iteration, escape test and square root.
// ----------------------------------------------------------------------------
module fet_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  fet_pkg::t_fet_status  i_status,
    output fet_pkg::t_fet_cmd     o_cmd,
    output logic                  o_busy,
    output logic                  o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_INIT,
        S_SQUARE,
        S_TEST,
        S_ROOT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_start;
        o_cmd.map        = (r_state == S_MAP);
        o_cmd.init       = (r_state == S_INIT);
        o_cmd.square     = (r_state == S_SQUARE);
        o_cmd.step       = (r_state == S_TEST) && i_status.go_on;
        o_cmd.root_start = (r_state == S_TEST) && !i_status.go_on;
    end

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MAP;
                end
            end
            S_MAP:    n_state = S_INIT;
            S_INIT:   n_state = S_SQUARE;
            S_SQUARE: n_state = S_TEST;
            S_TEST: begin
                n_state = i_status.go_on ? S_SQUARE : S_ROOT;
            end
            S_ROOT: begin
                if (i_status.root_done) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== design/fractal_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// fractal_escape_time_top
// Escape-time engine for Mandelbrot and Julia sets in Q4.28 fixed point.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// pixel     in         start high, busy low      i_pixel  (t_pixel_in)
// result    out        o_valid, one cycle        o_result (t_result)
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one pixel at a time; each iteration is a multiply state, then an update and
// escape test state; after the last test the bit-serial square root runs, and
// its done flag sets the registered result strobe
// a new pixel is taken in the cycle that carries the strobe
// synchronous active-low reset loads the register defaults and idles the block
// the result is shown for one cycle and cannot be held off
// ----------------------------------------------------------------------------
module fractal_escape_time_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  fet_pkg::t_pixel_in                  i_pixel,
    output logic                                o_valid,
    output fet_pkg::t_result                    o_result,
    input  logic                                i_cfg_we,
    input  logic [fet_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [fet_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    fet_pkg::t_fet_cmd    w_cmd;
    fet_pkg::t_fet_status w_status;

    fet_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    fet_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pixel    (i_pixel),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_result   (o_result)
    );

`ifndef SYNTHESIS
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.iteration_count != '0))
        else $error("result with zero iteration count");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.inside_two) |-> (o_result.half_modulus == '0))
        else $error("half modulus nonzero outside radius two");
`endif

endmodule

// ===== test/fet_escape_checker.sv =====
// ----------------------------------------------------------------------------
// fet_escape_checker
// Watches the pixel, result and register ports of the escape-time engine,
// keeps its own copy of the registers, predicts the escape count, the
// inside-two flag and the half modulus of every accepted pixel, and compares
// each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fet_escape_checker
    import fet_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  t_pixel_in                i_pixel,
    input  logic                     i_valid,
    input  t_result                  i_result,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_pending,
    output int                       o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    longint            x_min_q;
    longint            y_min_q;
    longint            step_q;
    logic [31:0]       radius_sq_q;
    logic [15:0]       max_iter_q;
    logic              julia_q;
    longint            c_re_q;
    longint            c_im_q;

    t_result           predicted_results[$];
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) begin
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = v;
        root  = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rem) begin
            probe = probe >> 2;
        end
        while (probe != 64'd0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic t_result predict_escape(input t_pixel_in p);
        longint       pt_re;
        longint       pt_im;
        longint       zr;
        longint       zi;
        longint       cr;
        longint       ci;
        longint       rr;
        longint       ii;
        longint       ri;
        logic [63:0]  m2;
        logic [63:0]  root;
        int unsigned  limit;
        int unsigned  count;
        logic         in_two;
        t_result      r;
        pt_re = clamp_word(x_min_q + longint'(p.pixel_x) * step_q);
        pt_im = clamp_word(y_min_q + longint'(p.pixel_y) * step_q);
        if (julia_q) begin
            zr = pt_re;
            zi = pt_im;
            cr = c_re_q;
            ci = c_im_q;
        end else begin
            zr = 0;
            zi = 0;
            cr = pt_re;
            ci = pt_im;
        end
        limit = max_iter_q;
        count = 0;
        do begin
            rr = (zr * zr) >>> FRAC_BITS;
            ii = (zi * zi) >>> FRAC_BITS;
            ri = (zr * zi) >>> (FRAC_BITS - 1);
            zr = clamp_word(rr - ii + cr);
            zi = clamp_word(ri + ci);
            count++;
            m2 = $unsigned(zr * zr) + $unsigned(zi * zi);
        end while ((m2 >> (2 * FRAC_BITS - 24)) < {32'd0, radius_sq_q} && count < limit);

        in_two = ((m2 >> (2 * FRAC_BITS)) < 64'd4) ||
                 ((m2 >> (2 * FRAC_BITS)) == 64'd4 && m2[2*FRAC_BITS-1:0] == '0);

        r.out_x           = p.pixel_x;
        r.out_y           = p.pixel_y;
        r.iteration_count = count[ITER_BITS-1:0];
        r.inside_two      = in_two;
        if (in_two) begin
            root = sqrt_floor(m2 >> (2 * FRAC_BITS - 30));
            r.half_modulus = (root > 64'd65535) ? 16'hFFFF : root[HALF_BITS-1:0];
        end else begin
            r.half_modulus = '0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            x_min_q     = longint'(RST_X_MIN);
            y_min_q     = longint'(RST_Y_MIN);
            step_q      = longint'(RST_STEP);
            radius_sq_q = RST_RADIUS_SQ;
            max_iter_q  = RST_MAX_ITER;
            julia_q     = 1'b0;
            c_re_q      = 0;
            c_im_q      = 0;
            predicted_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_MIN:     x_min_q     = longint'($signed(i_cfg_data));
                    CFG_Y_MIN:     y_min_q     = longint'($signed(i_cfg_data));
                    CFG_STEP:      step_q      = longint'(i_cfg_data[STEP_BITS-1:0]);
                    CFG_RADIUS_SQ: radius_sq_q = i_cfg_data;
                    CFG_MAX_ITER:  max_iter_q  = i_cfg_data[ITER_BITS-1:0];
                    CFG_MODE:      julia_q     = i_cfg_data[0];
                    CFG_C_RE:      c_re_q      = longint'($signed(i_cfg_data));
                    CFG_C_IM:      c_im_q      = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end

            if (i_valid) begin
                if (predicted_results.size() == 0) begin
                    $error("result transfer with no pixel outstanding");
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (i_result.out_x !== want.out_x) begin
                        $error("out_x: expected %0d, got %0d", want.out_x, i_result.out_x);
                        fail_count++;
                    end
                    if (i_result.out_y !== want.out_y) begin
                        $error("out_y: expected %0d, got %0d", want.out_y, i_result.out_y);
                        fail_count++;
                    end
                    if (i_result.iteration_count !== want.iteration_count) begin
                        $error("iteration_count: expected %0d, got %0d",
                               want.iteration_count, i_result.iteration_count);
                        fail_count++;
                    end
                    if (i_result.inside_two !== want.inside_two) begin
                        $error("inside_two: expected %0d, got %0d",
                               want.inside_two, i_result.inside_two);
                        fail_count++;
                    end
                    if (i_result.half_modulus !== want.half_modulus) begin
                        $error("half_modulus: expected %0d, got %0d",
                               want.half_modulus, i_result.half_modulus);
                        fail_count++;
                    end
                end
            end

            if (i_start && !i_busy) begin
                predicted_results.push_back(predict_escape(i_pixel));
            end
            o_pending <= predicted_results.size();
        end
    end

endmodule

// ===== test/tb_fractal_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// tb_fractal_escape_time_top
// Drives pixels and register writes into the escape-time engine: a directed
// run over the register extremes and the corner cases of the iteration,
// then random windows, radii, bounds and Julia constants with random pixels
// and random sender gaps in all phases but one. A checker beside the engine predicts and compares.
// ----------------------------------------------------------------------------
module tb_fractal_escape_time_top;
    import fet_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF       = 2;
    localparam int          RESET_CYCLES   = 6;
    localparam int          RANDOM_PHASES  = 12;
    localparam int          PHASE_PIXELS   = 73;
    localparam int          GAP_PERCENT    = 22;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int unsigned WATCHDOG_LIMIT = 400000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    t_pixel_in                pixel = '0;
    logic                     result_valid;
    t_result                  result;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int                       pending;
    int                       fail_count;
    logic                     gaps_on = 1'b1;
    int unsigned              stall_cycles = 0;

    always #(CLK_HALF) clk = ~clk;

    fractal_escape_time_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (pixel),
        .o_valid    (result_valid),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fet_escape_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_pixel      (pixel),
        .i_valid      (result_valid),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    task automatic send_pixel(input int unsigned x, input int unsigned y);
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= {x[PIXEL_BITS-1:0], y[PIXEL_BITS-1:0]};
        do begin
            @(posedge clk);
        end while (busy);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_setting();
        longint      step_v;
        longint      cx;
        longint      cy;
        logic [31:0] x_min_v;
        logic [31:0] y_min_v;
        logic [31:0] radius_v;
        logic [31:0] c_re_v;
        logic [31:0] c_im_v;
        if ($urandom_range(0, 3) == 0) begin
            x_min_v  = $urandom();
            y_min_v  = $urandom();
            step_v   = $urandom();
            radius_v = $urandom();
            c_re_v   = $urandom();
            c_im_v   = $urandom();
        end else begin
            // window around the interesting part of the plane
            step_v   = $urandom_range(32'h0000_8000, 32'h0008_0000);
            cx       = longint'($urandom_range(0, 32'h2000_0000)) - 64'sd402653184;
            cy       = longint'($urandom_range(0, 32'h2000_0000)) - 64'sd268435456;
            x_min_v  = 32'(cx - step_v * 2048);
            y_min_v  = 32'(cy - step_v * 2048);
            radius_v = $urandom_range(0, 1) ? RST_RADIUS_SQ
                                            : $urandom_range(0, 32'h1000_0000);
            c_re_v   = 32'(longint'($urandom_range(0, 32'h2000_0000)) - 64'sd268435456);
            c_im_v   = 32'(longint'($urandom_range(0, 32'h2000_0000)) - 64'sd268435456);
        end
        write_reg(CFG_X_MIN, x_min_v);
        write_reg(CFG_Y_MIN, y_min_v);
        write_reg(CFG_STEP, 32'(step_v));
        write_reg(CFG_RADIUS_SQ, radius_v);
        write_reg(CFG_MAX_ITER, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 300)
                                                           : $urandom_range(1, 48));
        write_reg(CFG_MODE, $urandom());
        write_reg(CFG_C_RE, c_re_v);
        write_reg(CFG_C_IM, c_im_v);
    endtask

    always @(posedge clk) begin
        if ((start && !busy) || result_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: corners, c = 0, c = -2 landing on |z| = 2, bit patterns
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(512, 512);
        send_pixel(0, 512);
        send_pixel(384, 512);
        send_pixel(12'hAAA, 12'h555);
        drain();

        // zero bound still iterates once
        write_reg(CFG_MAX_ITER, 32'd0);
        send_pixel(512, 512);
        send_pixel(100, 200);
        drain();

        // bound wider than the counter wraps
        write_reg(CFG_MAX_ITER, 32'h0001_0005);
        send_pixel(512, 512);
        drain();

        write_reg(CFG_MAX_ITER, 32'h0000_FFFF);
        send_pixel(512, 512);
        send_pixel(0, 0);
        drain();

        write_reg(CFG_MAX_ITER, 32'd16);
        write_reg(CFG_RADIUS_SQ, 32'd0);
        send_pixel(512, 512);
        drain();

        // radius never reached: saturation through the whole loop
        write_reg(CFG_RADIUS_SQ, 32'hFFFF_FFFF);
        send_pixel(4095, 4095);
        send_pixel(0, 0);
        drain();

        // mapping starts at both word extremes and saturates at the top
        write_reg(CFG_RADIUS_SQ, RST_RADIUS_SQ);
        write_reg(CFG_X_MIN, 32'h7FFF_FFFF);
        write_reg(CFG_Y_MIN, 32'h8000_0000);
        write_reg(CFG_STEP, 32'hFFFF_FFFF);
        send_pixel(4095, 4095);
        send_pixel(0, 0);
        send_pixel(1, 1);
        drain();

        // julia with extreme constants
        write_reg(CFG_X_MIN, 32'(RST_X_MIN));
        write_reg(CFG_Y_MIN, 32'(RST_Y_MIN));
        write_reg(CFG_STEP, 32'h0004_0000);
        write_reg(CFG_MODE, 32'hFFFF_FFFF);
        write_reg(CFG_C_RE, 32'h8000_0000);
        write_reg(CFG_C_IM, 32'h7FFF_FFFF);
        write_reg(CFG_RADIUS_SQ, 32'hFFFF_FFFF);
        send_pixel(2048, 2048);
        send_pixel(0, 4095);
        drain();

        write_reg(CFG_RADIUS_SQ, RST_RADIUS_SQ);
        write_reg(CFG_MAX_ITER, 32'd64);
        write_reg(CFG_C_RE, 32'(-64'sd214748365));
        write_reg(CFG_C_IM, 32'd41875931);
        send_pixel(2048, 2048);
        send_pixel(1000, 3000);
        send_pixel(3500, 500);
        drain();

        write_reg(CFG_MODE, 32'hFFFF_FFFE);
        send_pixel(2048, 2048);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            gaps_on = (phase != 1);
            random_setting();
            for (n = 0; n < PHASE_PIXELS; n++) begin
                send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/fet_pkg.sv
design/fet_sqrt.sv
design/fet_dp.sv
design/fet_ctrl.sv
design/fractal_escape_time_top.sv
test/fet_escape_checker.sv
test/tb_fractal_escape_time_top.sv
